// File: hdl/tiid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tiid_pkg;

    // Number of MD5 rounds, one cell each, plus the finishing register.
    localparam int TIID_ROUNDS  = 64;
    localparam int TIID_LATENCY = TIID_ROUNDS + 1;

    // Mask applied to the top byte of the new identifier (clears universal/local).
    localparam logic [7:0] TIID_UL_MASK = 8'hfd;

    // MD5 initial chaining values.
    localparam logic [31:0] TIID_IV_A = 32'h67452301;
    localparam logic [31:0] TIID_IV_B = 32'hefcdab89;
    localparam logic [31:0] TIID_IV_C = 32'h98badcfe;
    localparam logic [31:0] TIID_IV_D = 32'h10325476;

    // Constant padding words of the single block (message length 128 bits).
    localparam logic [31:0] TIID_PAD_WORD = 32'h00000080;
    localparam logic [31:0] TIID_LEN_WORD = 32'h00000080;
    localparam logic [3:0]  TIID_PAD_IDX  = 4'd4;
    localparam logic [3:0]  TIID_LEN_IDX  = 4'd14;

    localparam logic [0:63][31:0] TIID_K = {
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [0:15][4:0] TIID_S = {
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    typedef struct packed {
        logic [63:0] iface_id;
        logic [63:0] history_token;
    } t_tiid_in;

    typedef struct packed {
        logic [63:0] new_iface_id;
        logic [63:0] new_token;
    } t_tiid_out;

    // Working state carried from cell to cell: chaining words and the four
    // message words that come from the transaction.
    typedef struct packed {
        logic [31:0]      a;
        logic [31:0]      b;
        logic [31:0]      c;
        logic [31:0]      d;
        logic [3:0][31:0] m;
    } t_tiid_cell;

    function automatic logic [31:0] bswap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    // Message word index used by a round.
    function automatic logic [3:0] msg_index(input logic [5:0] round);
        logic [3:0] i4;
        logic [3:0] g;
        i4 = round[3:0];
        case (round[5:4])
            2'd0:    g = i4;
            2'd1:    g = 4'(i4 * 4'd5 + 4'd1);
            2'd2:    g = 4'(i4 * 4'd3 + 4'd5);
            2'd3:    g = 4'(i4 * 4'd7);
            default: g = i4;
        endcase
        return g;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] w;
        w = {x, x} << s;
        return w[63:32];
    endfunction

endpackage

`default_nettype wire

// File: hdl/tiid_round_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module tiid_round_cell (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [5:0]           i_round,
    input  wire logic                 i_valid,
    input  wire tiid_pkg::t_tiid_cell i_state,
    output logic                      o_valid,
    output tiid_pkg::t_tiid_cell      o_state
);

    logic                 r_valid;
    tiid_pkg::t_tiid_cell r_state;
    tiid_pkg::t_tiid_cell n_state;
    logic [31:0]          f;
    logic [31:0]          msg;
    logic [31:0]          sum;
    logic [3:0]           g;

    always_comb begin
        case (i_round[5:4])
            2'd0:    f = (i_state.b & i_state.c) | (~i_state.b & i_state.d);
            2'd1:    f = (i_state.d & i_state.b) | (~i_state.d & i_state.c);
            2'd2:    f = i_state.b ^ i_state.c ^ i_state.d;
            2'd3:    f = i_state.c ^ (i_state.b | ~i_state.d);
            default: f = '0;
        endcase

        // Only the first four words come from the transaction; the rest of
        // the block is fixed padding.
        g = tiid_pkg::msg_index(i_round);
        if (g < 4'd4) begin
            msg = i_state.m[g[1:0]];
        end else if (g == tiid_pkg::TIID_PAD_IDX) begin
            msg = tiid_pkg::TIID_PAD_WORD;
        end else if (g == tiid_pkg::TIID_LEN_IDX) begin
            msg = tiid_pkg::TIID_LEN_WORD;
        end else begin
            msg = '0;
        end

        sum = f + i_state.a + tiid_pkg::TIID_K[i_round] + msg;

        n_state   = i_state;
        n_state.a = i_state.d;
        n_state.d = i_state.c;
        n_state.c = i_state.b;
        n_state.b = i_state.b
                  + tiid_pkg::rotl32(sum, tiid_pkg::TIID_S[{i_round[5:4], i_round[1:0]}]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_state <= n_state;
    end

    assign o_valid = r_valid;
    assign o_state = r_state;

endmodule

`default_nettype wire

// File: hdl/tiid_finish.sv
`timescale 1ns / 1ps
`default_nettype none

module tiid_finish (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire tiid_pkg::t_tiid_cell i_state,
    output logic                      o_valid,
    output tiid_pkg::t_tiid_out       o_result
);

    logic                r_valid;
    tiid_pkg::t_tiid_out r_result;
    tiid_pkg::t_tiid_out n_result;
    logic [31:0]         h0;
    logic [31:0]         h1;
    logic [31:0]         h2;
    logic [31:0]         h3;

    always_comb begin
        h0 = tiid_pkg::TIID_IV_A + i_state.a;
        h1 = tiid_pkg::TIID_IV_B + i_state.b;
        h2 = tiid_pkg::TIID_IV_C + i_state.c;
        h3 = tiid_pkg::TIID_IV_D + i_state.d;

        // Digest bytes leave each word least significant byte first.
        n_result.new_iface_id = {tiid_pkg::bswap32(h0), tiid_pkg::bswap32(h1)};
        n_result.new_token    = {tiid_pkg::bswap32(h2), tiid_pkg::bswap32(h3)};
        n_result.new_iface_id[63:56] = n_result.new_iface_id[63:56]
                                     & tiid_pkg::TIID_UL_MASK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// File: hdl/temp_iface_id_md5.sv
`timescale 1ns / 1ps
`default_nettype none

// Temporary interface identifier generator. Each transaction carries a 64-bit
// interface identifier and a 64-bit history token; the block hashes the two
// (identifier first, each most significant byte first) with MD5 as one padded
// block and returns digest bytes 0 to 7 as the new identifier, with the
// universal/local bit cleared, and digest bytes 8 to 15 as the next history
// token. A transaction is taken on any clock edge where start is high; busy
// stays low, so a new transaction may be started in every cycle. The hash
// runs through a chain of 64 round cells, one MD5 round per cell, followed by
// one register that adds the initial chaining values and forms the result.
// The result of a transaction therefore appears on o_result with o_valid high
// once it has passed the round cells and the finishing register, in order, each
// result shown for a single cycle. The receiver cannot stall the block and must
// take each result in the cycle in which o_valid is high. Reset clears all
// transactions in flight; after reset no result comes out until a new one is done.

module temp_iface_id_md5 (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire tiid_pkg::t_tiid_in  i_data,
    output logic                     o_valid,
    output tiid_pkg::t_tiid_out      o_result
);

    logic                 chain_valid [0:tiid_pkg::TIID_ROUNDS];
    tiid_pkg::t_tiid_cell chain_state [0:tiid_pkg::TIID_ROUNDS];

    // The pipeline never backs up, so the block is always ready.
    assign busy = 1'b0;

    // Load the chaining values and turn the big-endian fields into the
    // little-endian message words that MD5 works on.
    always_comb begin
        chain_valid[0]        = start;
        chain_state[0].a      = tiid_pkg::TIID_IV_A;
        chain_state[0].b      = tiid_pkg::TIID_IV_B;
        chain_state[0].c      = tiid_pkg::TIID_IV_C;
        chain_state[0].d      = tiid_pkg::TIID_IV_D;
        chain_state[0].m[0]   = tiid_pkg::bswap32(i_data.iface_id[63:32]);
        chain_state[0].m[1]   = tiid_pkg::bswap32(i_data.iface_id[31:0]);
        chain_state[0].m[2]   = tiid_pkg::bswap32(i_data.history_token[63:32]);
        chain_state[0].m[3]   = tiid_pkg::bswap32(i_data.history_token[31:0]);
    end

    // One cell per round; each cell hands its state to the next every cycle.
    for (genvar gi = 0; gi < tiid_pkg::TIID_ROUNDS; gi++) begin : g_round
        tiid_round_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_round (6'(gi)),
            .i_valid (chain_valid[gi]),
            .i_state (chain_state[gi]),
            .o_valid (chain_valid[gi + 1]),
            .o_state (chain_state[gi + 1])
        );
    end

    tiid_finish u_finish (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (chain_valid[tiid_pkg::TIID_ROUNDS]),
        .i_state  (chain_state[tiid_pkg::TIID_ROUNDS]),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

// File: hdl/tiid_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tiid_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                o_valid,
    input wire tiid_pkg::t_tiid_out o_result
);

    // Cycles since reset was released, saturating at the pipeline latency.
    logic [6:0] r_up;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up <= '0;
        end else if (r_up < 7'(tiid_pkg::TIID_LATENCY)) begin
            r_up <= r_up + 7'd1;
        end
    end

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_up >= 7'(tiid_pkg::TIID_LATENCY)) |->
            (o_valid == $past(start && !busy, tiid_pkg::TIID_LATENCY)))
        else $error("result strobe does not match a transaction started 65 cycles ago");

    a_quiet_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_up < 7'(tiid_pkg::TIID_LATENCY)) |-> !o_valid)
        else $error("result before the pipeline could have filled");

    a_ul_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_result.new_iface_id[57])
        else $error("universal/local bit set in new identifier");

endmodule

bind temp_iface_id_md5 tiid_checker u_tiid_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

`default_nettype wire
